/* rtl/sle_pkg.sv */
package sle_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 9;
  localparam int DATA_W   = 32;
  localparam int QDEPTH   = 2;

  typedef enum logic [2:0] {
    OP_INS  = 3'd0,
    OP_DEL  = 3'd1,
    OP_GET  = 3'd2,
    OP_LOC  = 3'd3,
    OP_PRED = 3'd4,
    OP_SUCC = 3'd5,
    OP_CLR  = 3'd6,
    OP_NOP  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_NONE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_CAP,
    S_DEL_RD,
    S_DEL_WR,
    S_GET_CAP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_NB_CAP,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [CNT_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } item_t;

endpackage

/* rtl/sle_front.sv */
module sle_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 cmd,
  input  logic [sle_pkg::CNT_W-1:0]  position,
  input  logic [sle_pkg::DATA_W-1:0] value_in,
  output logic                       q_valid,
  output sle_pkg::item_t             q_item,
  input  logic                       q_pop
);

  sle_pkg::item_t slots [sle_pkg::QDEPTH];
  logic [$clog2(sle_pkg::QDEPTH)-1:0] wr_ptr;
  logic [$clog2(sle_pkg::QDEPTH)-1:0] rd_ptr;
  logic [$clog2(sle_pkg::QDEPTH+1)-1:0] fill;
  sle_pkg::item_t item;
  logic push;
  logic pop;

  // Command 7 has no meaning and is carried as a no-op.
  always_comb begin
    case (cmd)
      sle_pkg::OP_INS:  item.op = sle_pkg::OP_INS;
      sle_pkg::OP_DEL:  item.op = sle_pkg::OP_DEL;
      sle_pkg::OP_GET:  item.op = sle_pkg::OP_GET;
      sle_pkg::OP_LOC:  item.op = sle_pkg::OP_LOC;
      sle_pkg::OP_PRED: item.op = sle_pkg::OP_PRED;
      sle_pkg::OP_SUCC: item.op = sle_pkg::OP_SUCC;
      sle_pkg::OP_CLR:  item.op = sle_pkg::OP_CLR;
      default:          item.op = sle_pkg::OP_NOP;
    endcase
    item.position = position;
    item.value    = value_in;
  end

  assign in_stall = (fill == ($clog2(sle_pkg::QDEPTH+1))'(sle_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/sle_back.sv */
module sle_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       mode_lt,
  input  logic                       q_valid,
  input  sle_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [sle_pkg::CNT_W-1:0]  position_out,
  output logic [sle_pkg::DATA_W-1:0] value_out,
  output logic [sle_pkg::CNT_W-1:0]  list_length,
  output logic                       list_empty
);

  localparam int AW = sle_pkg::ADDR_W;
  localparam int CW = sle_pkg::CNT_W;
  localparam int DW = sle_pkg::DATA_W;

  logic [DW-1:0] mem [sle_pkg::CAPACITY];
  logic [DW-1:0] rdata;

  sle_pkg::state_t  state, state_next;
  sle_pkg::item_t   cur, cur_next;
  sle_pkg::status_t res_status, res_status_next;
  logic [CW-1:0]    k, k_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [CW-1:0]    res_pos, res_pos_next;
  logic [DW-1:0]    res_val, res_val_next;
  logic             out_valid_next;
  logic             load;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DW-1:0]    wdata;
  logic [AW-1:0]    raddr;
  logic             hit;
  logic [CW:0]      cnt_plus1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign cnt_plus1 = {1'b0, cnt} + 1'b1;

  always_comb begin
    if (cur.op == sle_pkg::OP_LOC && mode_lt) begin
      hit = $signed(rdata) < $signed(cur.value);
    end else begin
      hit = (rdata == cur.value);
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    k_next          = k;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_val_next    = res_val;
    q_pop           = 1'b0;
    load            = 1'b0;
    we              = 1'b0;
    waddr           = '0;
    wdata           = cur.value;
    raddr           = '0;

    case (state)
      sle_pkg::S_IDLE: begin
        res_status_next = sle_pkg::ST_OK;
        res_pos_next    = '0;
        res_val_next    = '0;
        // Delete and get start their read straight from the queue head.
        raddr           = AW'(q_item.position - 1'b1);
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_next = q_item;
          case (q_item.op)
            sle_pkg::OP_INS: begin
              if (q_item.position == '0 || {1'b0, q_item.position} > cnt_plus1) begin
                res_status_next = sle_pkg::ST_BADPOS;
                state_next      = sle_pkg::S_DONE;
              end else if (cnt == CW'(sle_pkg::CAPACITY)) begin
                res_status_next = sle_pkg::ST_FULL;
                state_next      = sle_pkg::S_DONE;
              end else if (cnt >= q_item.position) begin
                k_next     = cnt;
                state_next = sle_pkg::S_INS_RD;
              end else begin
                state_next = sle_pkg::S_INS_PUT;
              end
            end
            sle_pkg::OP_DEL, sle_pkg::OP_GET: begin
              if (q_item.position == '0 || q_item.position > cnt) begin
                res_status_next = sle_pkg::ST_BADPOS;
                state_next      = sle_pkg::S_DONE;
              end else if (q_item.op == sle_pkg::OP_DEL) begin
                state_next = sle_pkg::S_DEL_CAP;
              end else begin
                state_next = sle_pkg::S_GET_CAP;
              end
            end
            sle_pkg::OP_LOC, sle_pkg::OP_PRED, sle_pkg::OP_SUCC: begin
              k_next = '0;
              if (cnt == '0) begin
                res_status_next = sle_pkg::ST_NONE;
                state_next      = sle_pkg::S_DONE;
              end else begin
                state_next = sle_pkg::S_SCAN_RD;
              end
            end
            sle_pkg::OP_CLR: begin
              cnt_next   = '0;
              state_next = sle_pkg::S_DONE;
            end
            default: begin
              state_next = sle_pkg::S_DONE;
            end
          endcase
        end
      end

      // Insert shifts entries up from the tail, one read and one write each.
      sle_pkg::S_INS_RD: begin
        raddr      = AW'(k - 1'b1);
        state_next = sle_pkg::S_INS_WR;
      end
      sle_pkg::S_INS_WR: begin
        we     = 1'b1;
        waddr  = AW'(k);
        wdata  = rdata;
        k_next = k - 1'b1;
        if (k > cur.position) begin
          state_next = sle_pkg::S_INS_RD;
        end else begin
          state_next = sle_pkg::S_INS_PUT;
        end
      end
      sle_pkg::S_INS_PUT: begin
        we         = 1'b1;
        waddr      = AW'(cur.position - 1'b1);
        wdata      = cur.value;
        cnt_next   = cnt + 1'b1;
        state_next = sle_pkg::S_DONE;
      end

      sle_pkg::S_DEL_CAP: begin
        res_val_next = rdata;
        k_next       = cur.position;
        if (cur.position < cnt) begin
          state_next = sle_pkg::S_DEL_RD;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = sle_pkg::S_DONE;
        end
      end
      sle_pkg::S_DEL_RD: begin
        raddr      = AW'(k);
        state_next = sle_pkg::S_DEL_WR;
      end
      sle_pkg::S_DEL_WR: begin
        we     = 1'b1;
        waddr  = AW'(k - 1'b1);
        wdata  = rdata;
        k_next = k + 1'b1;
        if ({1'b0, k} + 1'b1 < {1'b0, cnt}) begin
          state_next = sle_pkg::S_DEL_RD;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = sle_pkg::S_DONE;
        end
      end

      sle_pkg::S_GET_CAP: begin
        res_val_next = rdata;
        state_next   = sle_pkg::S_DONE;
      end

      sle_pkg::S_SCAN_RD: begin
        raddr      = AW'(k);
        state_next = sle_pkg::S_SCAN_CMP;
      end
      sle_pkg::S_SCAN_CMP: begin
        if (hit) begin
          case (cur.op)
            sle_pkg::OP_LOC: begin
              res_pos_next = k + 1'b1;
              state_next   = sle_pkg::S_DONE;
            end
            sle_pkg::OP_PRED: begin
              if (k == '0) begin
                res_status_next = sle_pkg::ST_NONE;
                state_next      = sle_pkg::S_DONE;
              end else begin
                raddr        = AW'(k - 1'b1);
                res_pos_next = k;
                state_next   = sle_pkg::S_NB_CAP;
              end
            end
            default: begin
              if ({1'b0, k} + 1'b1 < {1'b0, cnt}) begin
                raddr        = AW'(k + 1'b1);
                res_pos_next = k + 2'd2;
                state_next   = sle_pkg::S_NB_CAP;
              end else begin
                res_status_next = sle_pkg::ST_NONE;
                state_next      = sle_pkg::S_DONE;
              end
            end
          endcase
        end else begin
          k_next = k + 1'b1;
          if ({1'b0, k} + 1'b1 < {1'b0, cnt}) begin
            state_next = sle_pkg::S_SCAN_RD;
          end else begin
            res_status_next = sle_pkg::ST_NONE;
            state_next      = sle_pkg::S_DONE;
          end
        end
      end
      sle_pkg::S_NB_CAP: begin
        res_val_next = rdata;
        state_next   = sle_pkg::S_DONE;
      end

      sle_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = sle_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sle_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_next = load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sle_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    k          <= k_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_val    <= res_val_next;
    if (load) begin
      status       <= res_status;
      position_out <= res_pos;
      value_out    <= res_val;
      list_length  <= cnt;
      list_empty   <= (cnt == '0);
    end
  end

endmodule

/* rtl/sequential_list_engine.sv */
// Channel   Direction  Handshake          Beat contents
// input     in         in_valid/in_stall  cmd, position, value_in
// result    out        out_valid/out_stall status, position_out, value_out,
//                                         list_length, list_empty
// config    in         cfg_valid/cfg_ready locate_mode
//
// Each stored entry that an insert or delete shifts takes one registered read and
// one write; a search does one registered read per entry it compares. The entry
// memory has one write port and one registered read port.
// Reset is synchronous; it empties the list and sets the stored locate mode to 1.
// A two-beat queue lets new commands enter while one is worked on.
// A finished result waits in the output register while out_stall is high.
module sequential_list_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       cmd,
  input  logic [sle_pkg::CNT_W-1:0]        position,
  input  logic signed [sle_pkg::DATA_W-1:0] value_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [sle_pkg::CNT_W-1:0]        position_out,
  output logic signed [sle_pkg::DATA_W-1:0] value_out,
  output logic [sle_pkg::CNT_W-1:0]        list_length,
  output logic                             list_empty,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             locate_mode
);

  logic           mode_lt;
  logic           q_valid;
  logic           q_pop;
  sle_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_lt <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mode_lt <= locate_mode;
    end
  end

  sle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .position (position),
    .value_in (value_in),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .mode_lt      (mode_lt),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .position_out (position_out),
    .value_out    (value_out),
    .list_length  (list_length),
    .list_empty   (list_empty)
  );

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> list_length <= sle_pkg::CNT_W'(sle_pkg::CAPACITY))
    else $error("list length beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (list_empty == (list_length == '0)))
    else $error("empty flag disagrees with length");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sle_pkg::ST_FULL) |->
      list_length == sle_pkg::CNT_W'(sle_pkg::CAPACITY))
    else $error("full status with room left");
`endif

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES = 2 * sle_pkg::CAPACITY + 16;

  typedef struct {
    sle_pkg::status_t             st;
    logic [sle_pkg::CNT_W-1:0]    pos;
    logic signed [31:0]           val;
    logic [sle_pkg::CNT_W-1:0]    len;
    logic                         empty;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] entries[sle_pkg::CAPACITY];
    int                 count;
    bit                 less_mode;
    list_result_t       expected_results[$];
    int                 errors;

    function new();
      count = 0;
      less_mode = 1'b1;
      errors = 0;
    endfunction

    function int find_equal(logic signed [31:0] v);
      int k;
      k = 0;
      while (k < count && entries[k] != v) k++;
      return k;
    endfunction

    function void note_command(sle_pkg::op_t op, int pos, logic signed [31:0] v);
      list_result_t r;
      int k;
      r.st = sle_pkg::ST_OK;
      r.pos = '0;
      r.val = '0;
      case (op)
        sle_pkg::OP_INS: begin
          if (pos < 1 || pos > count + 1) r.st = sle_pkg::ST_BADPOS;
          else if (count >= sle_pkg::CAPACITY) r.st = sle_pkg::ST_FULL;
          else begin
            for (k = count; k >= pos; k--) entries[k] = entries[k-1];
            entries[pos-1] = v;
            count++;
          end
        end
        sle_pkg::OP_DEL: begin
          if (pos < 1 || pos > count) r.st = sle_pkg::ST_BADPOS;
          else begin
            r.val = entries[pos-1];
            for (k = pos; k < count; k++) entries[k-1] = entries[k];
            count--;
          end
        end
        sle_pkg::OP_GET: begin
          if (pos < 1 || pos > count) r.st = sle_pkg::ST_BADPOS;
          else r.val = entries[pos-1];
        end
        sle_pkg::OP_LOC: begin
          for (k = 0; k < count; k++)
            if (less_mode ? (entries[k] < v) : (entries[k] == v)) break;
          if (k < count) r.pos = sle_pkg::CNT_W'(k + 1);
          else r.st = sle_pkg::ST_NONE;
        end
        sle_pkg::OP_PRED: begin
          k = find_equal(v);
          if (k < count && k > 0) begin
            r.val = entries[k-1];
            r.pos = sle_pkg::CNT_W'(k);
          end else r.st = sle_pkg::ST_NONE;
        end
        sle_pkg::OP_SUCC: begin
          k = find_equal(v);
          if (k + 1 < count) begin
            r.val = entries[k+1];
            r.pos = sle_pkg::CNT_W'(k + 2);
          end else r.st = sle_pkg::ST_NONE;
        end
        sle_pkg::OP_CLR: count = 0;
        default: ;
      endcase
      r.len = sle_pkg::CNT_W'(count);
      r.empty = (count == 0);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [sle_pkg::CNT_W-1:0] pos,
                               logic signed [31:0] v,
                               logic [sle_pkg::CNT_W-1:0] len, logic empty);
      list_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected (status %0d)", $time, st);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
      if (pos !== e.pos) begin
        $display("%0t: position_out expected %0d actual %0d", $time, e.pos, pos);
        errors++;
      end
      if (v !== e.val) begin
        $display("%0t: value_out expected %0d actual %0d", $time, e.val, v);
        errors++;
      end
      if (len !== e.len) begin
        $display("%0t: list_length expected %0d actual %0d", $time, e.len, len);
        errors++;
      end
      if (empty !== e.empty) begin
        $display("%0t: list_empty expected %0b actual %0b", $time, e.empty, empty);
        errors++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [2:0]                       cmd = '0;
  logic [sle_pkg::CNT_W-1:0]        position = '0;
  logic signed [31:0]               value_in = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       status;
  logic [sle_pkg::CNT_W-1:0]        position_out;
  logic signed [31:0]               value_out;
  logic [sle_pkg::CNT_W-1:0]        list_length;
  logic                             list_empty;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic                             locate_mode = 1'b1;

  list_scoreboard sb = new();
  int  cycle_count = 0;
  int  long_hold = 0;
  bit  quiet = 1'b0;

  sequential_list_engine dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, position_out, value_out, list_length, list_empty);

  // Receiver: random stall bursts, plus a long hold-off when asked for.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall = 1'b1;
        long_hold--;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(0, 15);
      end else out_stall = 1'b0;
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_cmd(sle_pkg::op_t op, int pos, logic signed [31:0] v);
    cmd = op;
    position = sle_pkg::CNT_W'(pos);
    value_in = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_command(op, pos, v);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(bit m);
    wait_idle();
    locate_mode = m;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.less_mode = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && sb.count > 0) return sb.entries[$urandom_range(0, sb.count - 1)];
    if (r < 60) return $urandom_range(0, 7) - 4;
    if (r < 65) return 32'sh7fffffff;
    if (r < 70) return 32'sh80000000;
    return $urandom;
  endfunction

  function automatic int pick_pos(bit for_insert);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, sb.count + (for_insert ? 1 : 0) > 0 ?
                                         sb.count + (for_insert ? 1 : 0) : 1);
    if (r < 90) return 0;
    if (r < 95) return $urandom_range(256, 257);
    return $urandom_range(0, 257);
  endfunction

  task automatic random_cmds(int n);
    int r;
    sle_pkg::op_t op;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 32) op = sle_pkg::OP_INS;
      else if (r < 47) op = sle_pkg::OP_DEL;
      else if (r < 60) op = sle_pkg::OP_GET;
      else if (r < 72) op = sle_pkg::OP_LOC;
      else if (r < 84) op = sle_pkg::OP_PRED;
      else if (r < 96) op = sle_pkg::OP_SUCC;
      else if (r < 98) op = sle_pkg::OP_CLR;
      else op = sle_pkg::OP_NOP;
      send_cmd(op, pick_pos(op == sle_pkg::OP_INS), pick_value());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_mode(1'b0);
    // Empty-list queries, then inserts at extremes, lookups and deletes.
    send_cmd(sle_pkg::OP_GET, 1, 0);
    send_cmd(sle_pkg::OP_DEL, 1, 0);
    send_cmd(sle_pkg::OP_PRED, 0, 0);
    send_cmd(sle_pkg::OP_SUCC, 0, 0);
    send_cmd(sle_pkg::OP_LOC, 0, 0);
    send_cmd(sle_pkg::OP_INS, 0, 5);
    send_cmd(sle_pkg::OP_INS, 2, 5);
    send_cmd(sle_pkg::OP_INS, 1, 32'sh7fffffff);
    send_cmd(sle_pkg::OP_INS, 1, 32'sh80000000);
    send_cmd(sle_pkg::OP_INS, 3, 0);
    send_cmd(sle_pkg::OP_INS, 2, -1);
    send_cmd(sle_pkg::OP_INS, 257, 7);
    send_cmd(sle_pkg::OP_GET, 1, 0);
    send_cmd(sle_pkg::OP_GET, 4, 0);
    send_cmd(sle_pkg::OP_GET, 5, 0);
    send_cmd(sle_pkg::OP_LOC, 0, 32'sh80000000);
    send_cmd(sle_pkg::OP_LOC, 0, 12345);
    send_cmd(sle_pkg::OP_PRED, 0, 32'sh80000000);
    send_cmd(sle_pkg::OP_SUCC, 0, 0);
    send_cmd(sle_pkg::OP_PRED, 0, 0);
    send_cmd(sle_pkg::OP_SUCC, 0, 32'sh80000000);
    send_cmd(sle_pkg::OP_DEL, 0, 0);
    send_cmd(sle_pkg::OP_DEL, 5, 0);
    send_cmd(sle_pkg::OP_DEL, 2, 0);
    send_cmd(sle_pkg::OP_NOP, 257, -1);
    send_cmd(sle_pkg::OP_CLR, 0, 0);

    write_mode(1'b1);
    random_cmds(60);
    write_mode(1'b0);
    random_cmds(50);

    // Fill the store to capacity, then hit the full and boundary cases.
    write_mode(1'b1);
    while (sb.count < sle_pkg::CAPACITY)
      send_cmd(sle_pkg::OP_INS,
               ($urandom_range(0, 3) == 0) ? $urandom_range(1, sb.count + 1)
                                           : sb.count + 1, pick_value());
    send_cmd(sle_pkg::OP_INS, 257, 1);
    send_cmd(sle_pkg::OP_INS, 1, 2);
    send_cmd(sle_pkg::OP_INS, 0, 3);
    send_cmd(sle_pkg::OP_GET, 256, 0);
    send_cmd(sle_pkg::OP_LOC, 0, 32'sh80000000);
    send_cmd(sle_pkg::OP_SUCC, 0, sb.entries[sle_pkg::CAPACITY-1]);
    long_hold = 400;
    repeat (8) send_cmd(sle_pkg::OP_GET, $urandom_range(1, 256), 0);
    send_cmd(sle_pkg::OP_DEL, 256, 0);
    send_cmd(sle_pkg::OP_DEL, 1, 0);

    // Final stretch runs with no idling on either side.
    quiet = 1'b1;
    random_cmds(30);
    send_cmd(sle_pkg::OP_CLR, 0, 0);
    random_cmds(10);

    wait_idle();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
